@@ src/accel_tilt_lowpass_defines.svh @@
// assertion macros used by the rtl file accel_tilt_lowpass.sv
`ifndef ACCEL_TILT_LOWPASS_DEFINES_SVH
`define ACCEL_TILT_LOWPASS_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ATL_ASSERT_IMPL(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("accel_tilt_lowpass check failed");
// next-cycle implication
`define ATL_ASSERT_NEXT(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("accel_tilt_lowpass check failed");
`else
`define ATL_ASSERT_IMPL(label, clk, rst, ant, cons)
`define ATL_ASSERT_NEXT(label, clk, rst, ant, cons)
`endif

`endif

@@ src/atl_pkg.sv @@
package atl_pkg;

   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;

   localparam int ROOT_W    = 24;            // floor(sqrt((a^2+b^2) << 16))
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int XW        = 28;            // cordic x/y datapath
   localparam int ZW        = 26;            // accumulated angle, degrees q16
   localparam int ATAN_IDX_W = 5;
   localparam int BATCH_W   = 8;
   localparam int WEIGHT_W  = 16;
   localparam int ANG_W     = 16;

   localparam logic [0:0] CSR_FILTER_WEIGHT   = 1'd0;
   localparam logic [0:0] CSR_SAMPLES_PER_RES = 1'd1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 16'd3932;
   localparam logic [BATCH_W-1:0]  SAMPLES_RESET = 8'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_ROOT,
      ST_CORDIC,
      ST_ROUND,
      ST_FILTER,
      ST_EMIT
   } atl_state_type;

   // atan(2^-i) in degrees, q16, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ZW-1:0] t;
      case (idx)
         5'd0:    t = 26'sd2949120;
         5'd1:    t = 26'sd1740967;
         5'd2:    t = 26'sd919879;
         5'd3:    t = 26'sd466945;
         5'd4:    t = 26'sd234379;
         5'd5:    t = 26'sd117304;
         5'd6:    t = 26'sd58666;
         5'd7:    t = 26'sd29335;
         5'd8:    t = 26'sd14668;
         5'd9:    t = 26'sd7334;
         5'd10:   t = 26'sd3667;
         5'd11:   t = 26'sd1833;
         5'd12:   t = 26'sd917;
         5'd13:   t = 26'sd458;
         5'd14:   t = 26'sd229;
         5'd15:   t = 26'sd115;
         5'd16:   t = 26'sd57;
         5'd17:   t = 26'sd29;
         5'd18:   t = 26'sd14;
         5'd19:   t = 26'sd7;
         5'd20:   t = 26'sd4;
         5'd21:   t = 26'sd2;
         5'd22:   t = 26'sd1;
         default: t = 26'sd0;
      endcase
      return t;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat16(input logic signed [31:0] v);
      logic signed [ANG_W-1:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/atl_isqrt.sv @@
module atl_isqrt
   import atl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CW = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ROOT_W+2:0] rem_t;
   logic [ROOT_W+2:0] trial;
   logic              fits;
   logic [ROOT_W+2:0] rem_in;

   // one result bit per cycle, restoring digit recurrence
   always_comb begin
      rem_t  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      fits   = (rem_t >= trial);
      rem_in = fits ? (rem_t - trial) : rem_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ src/atl_cordic.sv @@
module atl_cordic
   import atl_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [XW-1:0] px0,
   input  logic signed [XW-1:0] py0,
   output logic                 done,
   output logic signed [ZW-1:0] angle
);

   localparam int STW = $clog2(STEPS);

   logic signed [XW-1:0] px_ff;
   logic signed [XW-1:0] py_ff;
   logic signed [ZW-1:0] z_ff;
   logic [STW-1:0]       step_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;
   logic signed [ZW-1:0] t;

   // shared shift-add rotation, one micro-rotation per cycle
   always_comb begin
      dx = py_ff >>> step_ff;
      dy = px_ff >>> step_ff;
      t  = atan_deg(ATAN_IDX_W'(step_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STW'(1);
            if (step_ff == STW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         px_ff <= px0;
         py_ff <= py0;
         z_ff  <= '0;
      end else if (busy_ff) begin
         if (!py_ff[XW-1]) begin
            px_ff <= px_ff + dx;
            py_ff <= py_ff - dy;
            z_ff  <= z_ff + t;
         end else begin
            px_ff <= px_ff - dx;
            py_ff <= py_ff + dy;
            z_ff  <= z_ff - t;
         end
      end
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

@@ src/accel_tilt_lowpass.sv @@
// an accepted word passes through the squares, the 24-step square root, the cordic
// rotations, rounding and the filter update, first for roll and then for pitch; when a
// batch ends the result word is loaded in the emit state, which holds while an earlier
// result word still waits. A new word is taken only in idle, once the last one is
// through.
// reset: synchronous, clears both filters and the batch counter, drops any pending result
// word, and loads the default filter weight and batch length
`include "accel_tilt_lowpass_defines.svh"

module accel_tilt_lowpass
   import atl_pkg::*;
#(
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // accel_x, accel_y, accel_z

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // roll_angle, pitch_angle

   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int SHIFT     = 16 - ANGLE_FRAC_BITS;
   localparam int ROUND_ADD = 1 << (SHIFT - 1);

   atl_state_type state_ff, state_in;

   logic signed [15:0]   ax_ff, ay_ff, az_ff;
   logic                 axis_ff;
   logic [31:0]          sq_ff;
   logic                 zero_ff;
   logic signed [ANG_W-1:0] ang_ff;
   logic signed [ANG_W-1:0] roll_ff, pitch_ff;
   logic [BATCH_W-1:0]   count_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [BATCH_W-1:0]   spr_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;

   logic signed [16:0]   opp, side_a, side_b;
   logic signed [16:0]   mul_a, mul_b;
   logic signed [33:0]   prod;
   logic [31:0]          sq_sum;
   logic signed [ANG_W-1:0] f_cur;
   logic signed [16:0]   diff;
   logic signed [ANG_W-1:0] f_in;
   logic signed [ZW-1:0] z_rnd;
   logic signed [ANG_W-1:0] ang_in;
   logic [BATCH_W-1:0]   count_in;
   logic [BATCH_W-1:0]   limit;
   logic                 batch_done;
   logic                 root_start;
   logic                 emit_go;

   logic                 root_done;
   logic [ROOT_W-1:0]    root_val;
   logic                 cordic_done;
   logic signed [ZW-1:0] cordic_z;
   logic signed [XW-1:0] px0, py0;

   // roll: atan2(y, |x,z|), pitch: atan2(-x, |y,z|)
   always_comb begin
      if (!axis_ff) begin
         opp    = 17'(ay_ff);
         side_a = 17'(ax_ff);
      end else begin
         opp    = -17'(ax_ff);
         side_a = 17'(ay_ff);
      end
      side_b = 17'(az_ff);
      f_cur  = axis_ff ? pitch_ff : roll_ff;
      diff   = 17'(ang_ff) - 17'(f_cur);
   end

   // shared multiplier: squares, then the filter product
   always_comb begin
      case (state_ff)
         ST_SQ_A: begin
            mul_a = side_a;
            mul_b = side_a;
         end
         ST_SQ_B: begin
            mul_a = side_b;
            mul_b = side_b;
         end
         default: begin
            mul_a = diff;
            mul_b = $signed({1'b0, weight_ff});
         end
      endcase
      prod   = mul_a * mul_b;
      sq_sum = sq_ff + prod[31:0];
      f_in   = sat16(32'(f_cur) + 32'($signed(prod[33:16])));
   end

   always_comb begin
      z_rnd  = (cordic_z + ZW'(ROUND_ADD)) >>> SHIFT;
      ang_in = zero_ff ? '0 : sat16(32'(z_rnd));
      px0    = XW'($signed({1'b0, root_val}));
      py0    = XW'(opp) <<< 8;
   end

   always_comb begin
      count_in   = count_ff + BATCH_W'(1);
      limit      = (spr_ff == '0) ? BATCH_W'(1) : spr_ff;
      batch_done = (count_in >= limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      root_start = 1'b0;
      emit_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SQ_A;
            end
         end
         ST_SQ_A: begin
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_FILTER;
         end
         ST_FILTER: begin
            if (!axis_ff) begin
               state_in = ST_SQ_A;
            end else if (batch_done) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            emit_go = !rsp_valid_ff || rsp_tready;
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= 1'b0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         count_ff     <= '0;
         weight_ff    <= WEIGHT_RESET;
         spr_ff       <= SAMPLES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_FILTER_WEIGHT:   weight_ff <= csr_wdata;
               CSR_SAMPLES_PER_RES: spr_ff    <= csr_wdata[BATCH_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               axis_ff <= 1'b0;
            end
            ST_FILTER: begin
               if (!axis_ff) begin
                  roll_ff <= f_in;
                  axis_ff <= 1'b1;
               end else begin
                  pitch_ff <= f_in;
                  count_ff <= count_in;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  roll_ff      <= '0;
                  pitch_ff     <= '0;
                  count_ff     <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
      end
      if (state_ff == ST_SQ_A) begin
         sq_ff <= prod[31:0];
      end
      if (state_ff == ST_SQ_B) begin
         // both operands zero gives angle zero
         zero_ff <= (sq_sum == '0) && (opp == '0);
      end
      if (state_ff == ST_ROUND) begin
         ang_ff <= ang_in;
      end
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_data_ff <= {pitch_ff, roll_ff};
      end
   end

   atl_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({sq_sum, 16'h0000}),
      .done     (root_done),
      .root     (root_val)
   );

   atl_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (root_done),
      .px0   (px0),
      .py0   (py0),
      .done  (cordic_done),
      .angle (cordic_z)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ATL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_data_ff))
   `ATL_ASSERT_IMPL(a_root_in_wait, clock, reset, root_done, state_ff == ST_ROOT)
   `ATL_ASSERT_IMPL(a_cordic_in_wait, clock, reset, cordic_done, state_ff == ST_CORDIC)
   `ATL_ASSERT_NEXT(a_emit_clears, clock, reset, state_ff == ST_EMIT && emit_go, count_ff == '0 && roll_ff == '0 && pitch_ff == '0)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import atl_pkg::*;

   localparam int STEPS         = CORDIC_STEPS_DEF;
   localparam int FRAC          = ANGLE_FRAC_BITS_DEF;
   // covers one sample plus the result load, with some margin
   localparam int SETTLE_CYCLES = 2 * STEPS + 90;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASE_SAMPLES = 181;

   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } accel_word_type;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } tilt_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // accel_x, accel_y, accel_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // roll_angle, pitch_angle
   logic        csr_we = 1'b0;
   logic [0:0]  csr_addr = CSR_FILTER_WEIGHT;
   logic [15:0] csr_wdata = '0;

   accel_tilt_lowpass u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state, matches the block after reset
   int unsigned filt_weight = WEIGHT_RESET;
   int unsigned batch_len   = SAMPLES_RESET;
   int          roll_acc    = 0;
   int          pitch_acc   = 0;
   int unsigned batch_cnt   = 0;

   tilt_pair_type pending_angles[$];
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          fail_count = 0;
   int          samples_sent = 0;
   int          results_checked = 0;
   int          quiet_cycles = 0;

   function automatic int clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   // atan(2^-i) in degrees, q16, rounded to nearest
   function automatic longint atan_q16(int i);
      real deg;
      deg = $atan(1.0 / (2.0 ** i)) * 180.0 / 3.14159265358979323846;
      return longint'($floor(deg * 65536.0 + 0.5));
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // vectoring cordic on (|adj|, opp), angle in 2^-FRAC degrees
   function automatic int tilt_angle(longint opp, longint adj_a, longint adj_b);
      longint unsigned radicand;
      longint px;
      longint py;
      longint ang;
      longint dx;
      longint dy;
      int s;
      radicand = longint'(adj_a * adj_a + adj_b * adj_b) << 16;
      px = longint'(root_floor(radicand));
      py = opp * 256;
      ang = 0;
      s = 16 - FRAC;
      if (px == 0 && py == 0) return 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px = px + dx;
            py = py - dy;
            ang = ang + atan_q16(i);
         end else begin
            px = px - dx;
            py = py + dy;
            ang = ang - atan_q16(i);
         end
      end
      return clamp16((ang + (longint'(1) << (s - 1))) >>> s);
   endfunction

   function automatic int smooth(int f, int a);
      longint d;
      d = longint'(a) - longint'(f);
      return clamp16(longint'(f) + ((d * longint'(filt_weight)) >>> 16));
   endfunction

   function automatic void predict_tilt(accel_word_type s);
      tilt_pair_type p;
      int unsigned lim;
      longint      ax;
      longint      ay;
      longint      az;
      ax = longint'(s.x);
      ay = longint'(s.y);
      az = longint'(s.z);
      lim = (batch_len == 0) ? 1 : batch_len;
      roll_acc = smooth(roll_acc, tilt_angle(ay, ax, az));
      pitch_acc = smooth(pitch_acc, tilt_angle(-ax, ay, az));
      batch_cnt = (batch_cnt + 1) & 8'hff;
      if (batch_cnt >= lim) begin
         p.roll = 16'(roll_acc);
         p.pitch = 16'(pitch_acc);
         pending_angles.push_back(p);
         roll_acc = 0;
         pitch_acc = 0;
         batch_cnt = 0;
      end
   endfunction

   function automatic logic signed [15:0] rand_axis(int kind);
      int v;
      if (kind <= 3) begin
         v = $urandom_range(65535);
      end else if (kind == 4) begin
         case ($urandom_range(4))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = -1;
            3:       v = 0;
            default: v = 1;
         endcase
      end else if (kind <= 6) begin
         // roughly the span a sensor at rest gives
         v = int'($urandom_range(40000)) - 20000;
      end else if (kind == 7) begin
         v = int'($urandom_range(64)) - 32;
      end else begin
         v = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(65535));
      end
      return 16'(v);
   endfunction

   function automatic accel_word_type random_sample();
      accel_word_type s;
      int kind;
      kind = $urandom_range(9);
      s.x = rand_axis(kind);
      s.y = rand_axis(kind);
      s.z = rand_axis(kind);
      return s;
   endfunction

   task automatic send_sample(input accel_word_type s);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      predict_tilt(s);
   endtask

   task automatic send_xyz(input int x, input int y, input int z);
      accel_word_type s;
      s.x = 16'(x);
      s.y = 16'(y);
      s.z = 16'(z);
      send_sample(s);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_FILTER_WEIGHT) begin
         filt_weight = value;
      end else begin
         batch_len = value[7:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // upper byte of the length write is don't-care
   task automatic set_filter(input logic [15:0] weight, input logic [7:0] len);
      write_csr(CSR_FILTER_WEIGHT, weight);
      write_csr(CSR_SAMPLES_PER_RES, {8'($urandom_range(255)), len});
   endtask

   // stop sending, let every expected word arrive and the datapath go quiet
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      tilt_pair_type want;
      tilt_pair_type got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_angles.size() == 0) begin
               $error("unexpected result word roll=%0d pitch=%0d", got.roll, got.pitch);
               fail_count++;
            end else begin
               want = pending_angles.pop_front();
               results_checked++;
               if (got.roll !== want.roll) begin
                  $error("roll_angle expected %0d actual %0d", want.roll, got.roll);
                  fail_count++;
               end
               if (got.pitch !== want.pitch) begin
                  $error("pitch_angle expected %0d actual %0d", want.pitch, got.pitch);
                  fail_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // no register writes: reset weight and batch length of 100
   task automatic test_reset_defaults();
      for (int i = 0; i < 100; i++) send_sample(random_sample());
      wait_idle();
   endtask

   task automatic test_directed_extremes();
      set_filter(16'hffff, 8'd1);
      send_xyz(0, 0, 0);
      send_xyz(32767, 32767, 32767);
      send_xyz(-32768, -32768, -32768);
      send_xyz(-32768, 0, 0);
      send_xyz(32767, 0, 0);
      send_xyz(0, 32767, 0);
      send_xyz(0, -32768, 0);
      send_xyz(0, 0, 32767);
      send_xyz(0, 0, -32768);
      send_xyz(1, 0, 0);
      send_xyz(-1, 0, 0);
      send_xyz(0, 1, -1);
      send_xyz(-32768, 32767, 0);
      send_xyz(16384, -16384, 23170);
      send_xyz(-1, -1, -1);
      send_xyz(32767, -32768, 1);
      wait_idle();
      // zero weight keeps both filters at zero
      set_filter(16'h0000, 8'd1);
      send_xyz(32767, -32768, 100);
      send_xyz(-20000, 12345, -5);
      wait_idle();
   endtask

   task automatic test_batch_edges();
      // length zero behaves as one
      set_filter(16'h4000, 8'd0);
      repeat (3) send_sample(random_sample());
      wait_idle();
      // shorten the batch below what is already counted
      set_filter(16'(($urandom_range(65535))), 8'd6);
      repeat (4) send_sample(random_sample());
      wait_idle();
      write_csr(CSR_SAMPLES_PER_RES, 16'd2);
      repeat (3) send_sample(random_sample());
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       set_filter(16'd3932, 8'd4);
            1:       set_filter(16'hffff, 8'd1);
            2:       set_filter(16'h0000, 8'd7);
            3:       set_filter(16'($urandom_range(65535)), 8'd255);
            4:       set_filter(16'($urandom_range(65535)), 8'($urandom_range(1, 16)));
            5:       set_filter(16'h0001, 8'd2);
            6:       set_filter(16'($urandom_range(65535)), 8'd0);
            default: set_filter(16'h8000, 8'($urandom_range(1, 31)));
         endcase
         case (ph % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 54;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 54;
            end
            default: begin
               idle_pct = 10;
               stall_pct = 10;
            end
         endcase
         for (int i = 0; i < PHASE_SAMPLES; i++) begin
            send_sample(random_sample());
            // hold off mid-phase until the result queue runs dry
            if (ph == 4 && i == PHASE_SAMPLES / 2) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               while (pending_angles.size() != 0) @(posedge clock);
            end
         end
         wait_idle();
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_extremes();
      test_batch_edges();
      test_random_phases();
      wait_idle();
      $display("covered %0d samples and %0d checked tilt results", samples_sent,
               results_checked);
      $display("across reset defaults, axis extremes, batch-length edges and 8 filter settings");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
